// File: sv/esl_pkg.sv
// ============================================================================
// esl_pkg
// Shared types and constants of the signature-list parser.
// ============================================================================
package esl_pkg;

    localparam int LenBits     = 24;
    localparam int GuidBits    = 64;
    localparam int SizeBits    = 32;
    localparam int CfgIdxBits  = 3;
    localparam int CfgDataBits = 64;
    localparam int HdrBytes    = 28;
    localparam int OwnerBytes  = 16;
    localparam int HdrCntBits  = 5;
    localparam int DivCntBits  = $clog2(SizeBits);

    // Configuration register indexes.
    typedef enum logic [CfgIdxBits-1:0] {
        CFG_BLOB_LENGTH  = 3'd0,
        CFG_TYPE_A_LOW   = 3'd1,
        CFG_TYPE_A_HIGH  = 3'd2,
        CFG_TYPE_B_LOW   = 3'd3,
        CFG_TYPE_B_HIGH  = 3'd4,
        CFG_MATCH_ENABLE = 3'd5
    } t_cfg_idx;

    // Controller states.
    typedef enum logic [3:0] {
        ST_HDR,
        ST_CKA,
        ST_CKB,
        ST_CKC,
        ST_DIV,
        ST_CKEND,
        ST_SKIP,
        ST_LHDR,
        ST_OWNER,
        ST_DATA,
        ST_ERR,
        ST_DONE
    } t_state;

    // Datapath operations.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_HDR,
        OP_CKA,
        OP_CKB,
        OP_CKC,
        OP_DIV
    } t_op;

    // Entry counter loads.
    typedef enum logic [1:0] {
        ELD_NONE,
        ELD_OWNER,
        ELD_DATA,
        ELD_HS
    } t_eld;

    // Region counter loads.
    typedef enum logic [1:0] {
        RLD_NONE,
        RLD_SKIP,
        RLD_EL
    } t_rld;

    typedef struct packed {
        t_op  op;
        logic advance;
        logic dec_region;
        logic dec_entry;
        t_eld eld;
        t_rld rld;
        logic set_match;
        logic match_val;
        logic emit;
        logic is_data;
        logic last;
        logic empty;
        logic done;
        logic err;
    } t_cmd;

    typedef struct packed {
        logic restart;
        logic slot_free;
        logic active;
        logic short_hdr;
        logic rem_one;
        logic hcnt_zero;
        logic hcnt_last;
        logic region_one;
        logic entry_one;
        logic es_is16;
        logic hs_zero;
        logic e1;
        logic e2;
        logic el_lt_es;
        logic div_last;
        logic rem_nz;
        logic match_a;
        logic match_b;
    } t_stat;

endpackage

// File: sv/esl_in_if.sv
// ============================================================================
// esl_in_if
// Byte input channel of the signature-list parser.
// ============================================================================
interface esl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;

    modport source (output valid, output byte_value, input ready);
    modport sink   (input valid, input byte_value, output ready);
endinterface

// File: sv/esl_out_if.sv
// ============================================================================
// esl_out_if
// Result channel of the signature-list parser.
// ============================================================================
interface esl_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       is_data;
    logic       type_index;
    logic       entry_last;
    logic       entry_empty;
    logic       blob_done;
    logic       blob_error;

    modport source (output valid, output data_byte, output is_data, output type_index,
                    output entry_last, output entry_empty, output blob_done,
                    output blob_error, input ready);
    modport sink   (input valid, input data_byte, input is_data, input type_index,
                    input entry_last, input entry_empty, input blob_done,
                    input blob_error, output ready);
endinterface

// File: sv/esl_ctrl.sv
// ============================================================================
// esl_ctrl
// Parser state machine: sequences header capture, size checks and entries.
// ============================================================================
module esl_ctrl
    import esl_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   accept_state;
    logic   work;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_HDR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;

        accept_state = (r_state inside {ST_HDR, ST_SKIP, ST_LHDR, ST_OWNER, ST_DATA,
                                        ST_ERR, ST_DONE});
        o_in_ready   = accept_state && i_stat.slot_free;
        work         = i_in_valid && o_in_ready && i_stat.active;

        case (r_state)
            ST_HDR: begin
                if (work) begin
                    if (i_stat.hcnt_zero && i_stat.short_hdr) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.err  = 1'b1;
                        n_state    = ST_ERR;
                    end else begin
                        o_cmd.op      = OP_HDR;
                        o_cmd.advance = 1'b1;
                        if (i_stat.hcnt_last) begin
                            n_state = ST_CKA;
                        end
                    end
                end
            end
            ST_CKA: begin
                if (i_stat.slot_free) begin
                    o_cmd.op = OP_CKA;
                    n_state  = ST_CKB;
                end
            end
            ST_CKB: begin
                if (i_stat.slot_free) begin
                    if (i_stat.e1 || i_stat.e2) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.err  = 1'b1;
                        n_state    = ST_ERR;
                    end else begin
                        o_cmd.op = OP_CKB;
                        n_state  = ST_CKC;
                    end
                end
            end
            ST_CKC: begin
                if (i_stat.slot_free) begin
                    if (i_stat.el_lt_es) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.err  = 1'b1;
                        n_state    = ST_ERR;
                    end else begin
                        o_cmd.op = OP_CKC;
                        n_state  = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                o_cmd.op = OP_DIV;
                if (i_stat.div_last) begin
                    n_state = ST_CKEND;
                end
            end
            ST_CKEND: begin
                if (i_stat.slot_free) begin
                    if (i_stat.rem_nz) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.err  = 1'b1;
                        n_state    = ST_ERR;
                    end else if (i_stat.match_a || i_stat.match_b) begin
                        o_cmd.set_match = 1'b1;
                        o_cmd.match_val = !i_stat.match_a;
                        o_cmd.rld       = RLD_EL;
                        if (i_stat.hs_zero) begin
                            o_cmd.eld = ELD_OWNER;
                            n_state   = ST_OWNER;
                        end else begin
                            o_cmd.eld = ELD_HS;
                            n_state   = ST_LHDR;
                        end
                    end else begin
                        o_cmd.rld = RLD_SKIP;
                        n_state   = ST_SKIP;
                    end
                end
            end
            ST_SKIP: begin
                if (work) begin
                    o_cmd.advance    = 1'b1;
                    o_cmd.dec_region = 1'b1;
                    if (i_stat.region_one) begin
                        if (i_stat.rem_one) begin
                            o_cmd.emit = 1'b1;
                            o_cmd.done = 1'b1;
                            n_state    = ST_DONE;
                        end else begin
                            n_state = ST_HDR;
                        end
                    end
                end
            end
            ST_LHDR: begin
                if (work) begin
                    o_cmd.advance   = 1'b1;
                    o_cmd.dec_entry = 1'b1;
                    if (i_stat.entry_one) begin
                        o_cmd.eld = ELD_OWNER;
                        n_state   = ST_OWNER;
                    end
                end
            end
            ST_OWNER: begin
                if (work) begin
                    o_cmd.advance    = 1'b1;
                    o_cmd.dec_region = 1'b1;
                    o_cmd.dec_entry  = 1'b1;
                    if (i_stat.entry_one) begin
                        if (i_stat.es_is16) begin
                            o_cmd.emit  = 1'b1;
                            o_cmd.last  = 1'b1;
                            o_cmd.empty = 1'b1;
                            if (i_stat.region_one) begin
                                o_cmd.done = i_stat.rem_one;
                                n_state    = i_stat.rem_one ? ST_DONE : ST_HDR;
                            end else begin
                                o_cmd.eld = ELD_OWNER;
                            end
                        end else begin
                            o_cmd.eld = ELD_DATA;
                            n_state   = ST_DATA;
                        end
                    end
                end
            end
            ST_DATA: begin
                if (work) begin
                    o_cmd.advance    = 1'b1;
                    o_cmd.dec_region = 1'b1;
                    o_cmd.dec_entry  = 1'b1;
                    o_cmd.emit       = 1'b1;
                    o_cmd.is_data    = 1'b1;
                    if (i_stat.entry_one) begin
                        o_cmd.last = 1'b1;
                        if (i_stat.region_one) begin
                            o_cmd.done = i_stat.rem_one;
                            n_state    = i_stat.rem_one ? ST_DONE : ST_HDR;
                        end else begin
                            o_cmd.eld = ELD_OWNER;
                            n_state   = ST_OWNER;
                        end
                    end
                end
            end
            default: begin
                // Error and done states drop every byte.
            end
        endcase

        // Writing the blob length starts a new blob.
        if (i_stat.restart) begin
            n_state = ST_HDR;
        end
    end

endmodule

// File: sv/esl_dp.sv
// ============================================================================
// esl_dp
// Parser datapath: configuration, header fields, counters, size checks with a
// restoring remainder unit, and the output register.
// ============================================================================
module esl_dp
    import esl_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CfgIdxBits-1:0]  i_cfg_index,
    input  logic [CfgDataBits-1:0] i_cfg_data,
    input  logic [7:0]             i_byte_value,
    input  t_cmd                   i_cmd,
    output t_stat                  o_stat,
    esl_out_if.source              o_out
);

    localparam logic [SizeBits-1:0]   OwnerSize = SizeBits'(OwnerBytes);
    localparam logic [SizeBits-1:0]   HdrSize   = SizeBits'(HdrBytes);
    localparam logic [HdrCntBits-1:0] HdrLast   = HdrCntBits'(HdrBytes - 1);

    // Configuration registers.
    logic [LenBits-1:0]  r_len;
    logic [GuidBits-1:0] r_ta_lo, r_ta_hi, r_tb_lo, r_tb_hi;
    logic [1:0]          r_men;

    // Parse state.
    logic [LenBits-1:0]    r_offset;
    logic [LenBits-1:0]    r_start_rem;
    logic [HdrCntBits-1:0] r_hcnt;
    logic [GuidBits-1:0]   r_guid_lo, r_guid_hi;
    logic [SizeBits-1:0]   r_ls, r_hs, r_es;
    logic [SizeBits-1:0]   r_lsm, r_el;
    logic                  r_e1;
    logic [SizeBits-1:0]   r_region, r_entry;
    logic                  r_matched;

    // Remainder unit.
    logic [SizeBits:0]     r_div_rem;
    logic [SizeBits-1:0]   r_div_q;
    logic [DivCntBits-1:0] r_div_cnt;

    // Output register.
    logic       r_ov;
    logic [7:0] r_data;
    logic       r_is_data, r_tidx, r_last, r_empty, r_done, r_err;

    logic [LenBits-1:0] rem;
    logic [SizeBits:0]  trial;
    logic               restart;

    assign rem     = r_len - r_offset;
    assign trial   = {r_div_rem[SizeBits-1:0], r_div_q[SizeBits-1]};
    assign restart = i_cfg_we && (t_cfg_idx'(i_cfg_index) == CFG_BLOB_LENGTH);

    // Status toward the controller.
    always_comb begin
        o_stat.restart    = restart;
        o_stat.slot_free  = !r_ov || o_out.ready;
        o_stat.active     = r_offset < r_len;
        o_stat.short_hdr  = rem < LenBits'(HdrBytes);
        o_stat.rem_one    = rem == LenBits'(1);
        o_stat.hcnt_zero  = r_hcnt == '0;
        o_stat.hcnt_last  = r_hcnt == HdrLast;
        o_stat.region_one = r_region == SizeBits'(1);
        o_stat.entry_one  = r_entry == SizeBits'(1);
        o_stat.es_is16    = r_es == OwnerSize;
        o_stat.hs_zero    = r_hs == '0;
        o_stat.e1         = r_e1;
        o_stat.e2         = (r_hs > r_lsm) || (r_es < OwnerSize);
        o_stat.el_lt_es   = r_el < r_es;
        o_stat.div_last   = &r_div_cnt;
        o_stat.rem_nz     = r_div_rem != '0;
        o_stat.match_a    = r_men[0] && (r_guid_lo == r_ta_lo) && (r_guid_hi == r_ta_hi);
        o_stat.match_b    = r_men[1] && (r_guid_lo == r_tb_lo) && (r_guid_hi == r_tb_hi);
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_ta_lo <= '0;
            r_ta_hi <= '0;
            r_tb_lo <= '0;
            r_tb_hi <= '0;
            r_men   <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_BLOB_LENGTH:  r_len   <= i_cfg_data[LenBits-1:0];
                CFG_TYPE_A_LOW:   r_ta_lo <= i_cfg_data;
                CFG_TYPE_A_HIGH:  r_ta_hi <= i_cfg_data;
                CFG_TYPE_B_LOW:   r_tb_lo <= i_cfg_data;
                CFG_TYPE_B_HIGH:  r_tb_hi <= i_cfg_data;
                CFG_MATCH_ENABLE: r_men   <= i_cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

    // Blob offset, header index and matched type.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || restart) begin
            r_offset  <= '0;
            r_hcnt    <= '0;
            r_matched <= 1'b0;
        end else begin
            if (i_cmd.advance) begin
                r_offset <= r_offset + LenBits'(1);
            end
            if (i_cmd.op == OP_HDR) begin
                r_hcnt <= (r_hcnt == HdrLast) ? '0 : r_hcnt + HdrCntBits'(1);
            end
            if (i_cmd.set_match) begin
                r_matched <= i_cmd.match_val;
            end
        end
    end

    // Header capture, size checks and remainder steps.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_HDR: begin
                if (r_hcnt == '0) begin
                    r_start_rem <= rem;
                end
                if (r_hcnt < HdrCntBits'(8)) begin
                    r_guid_lo[8*r_hcnt[2:0] +: 8] <= i_byte_value;
                end else if (r_hcnt < HdrCntBits'(16)) begin
                    r_guid_hi[8*r_hcnt[2:0] +: 8] <= i_byte_value;
                end else if (r_hcnt < HdrCntBits'(20)) begin
                    r_ls[8*r_hcnt[1:0] +: 8] <= i_byte_value;
                end else if (r_hcnt < HdrCntBits'(24)) begin
                    r_hs[8*r_hcnt[1:0] +: 8] <= i_byte_value;
                end else begin
                    r_es[8*r_hcnt[1:0] +: 8] <= i_byte_value;
                end
            end
            OP_CKA: begin
                r_e1  <= (r_ls > SizeBits'(r_start_rem)) || (r_ls < HdrSize);
                r_lsm <= r_ls - HdrSize;
            end
            OP_CKB: begin
                r_el <= r_lsm - r_hs;
            end
            OP_CKC: begin
                r_div_rem <= '0;
                r_div_q   <= r_el;
                r_div_cnt <= '0;
            end
            OP_DIV: begin
                if (trial >= {1'b0, r_es}) begin
                    r_div_rem <= trial - {1'b0, r_es};
                end else begin
                    r_div_rem <= trial;
                end
                r_div_q   <= {r_div_q[SizeBits-2:0], 1'b0};
                r_div_cnt <= r_div_cnt + DivCntBits'(1);
            end
            default: begin
            end
        endcase
    end

    // Region and entry counters.
    always_ff @(posedge i_clk) begin
        case (i_cmd.rld)
            RLD_SKIP: r_region <= r_lsm;
            RLD_EL:   r_region <= r_el;
            default: begin
                if (i_cmd.dec_region) begin
                    r_region <= r_region - SizeBits'(1);
                end
            end
        endcase
        case (i_cmd.eld)
            ELD_OWNER: r_entry <= OwnerSize;
            ELD_DATA:  r_entry <= r_es - OwnerSize;
            ELD_HS:    r_entry <= r_hs;
            default: begin
                if (i_cmd.dec_entry) begin
                    r_entry <= r_entry - SizeBits'(1);
                end
            end
        endcase
    end

    // Output register; a result waits here until its transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_data    <= i_cmd.is_data ? i_byte_value : 8'd0;
            r_is_data <= i_cmd.is_data;
            r_tidx    <= (i_cmd.is_data || i_cmd.last) ? r_matched : 1'b0;
            r_last    <= i_cmd.last;
            r_empty   <= i_cmd.empty;
            r_done    <= i_cmd.done;
            r_err     <= i_cmd.err;
        end
    end

    assign o_out.valid       = r_ov;
    assign o_out.data_byte   = r_data;
    assign o_out.is_data     = r_is_data;
    assign o_out.type_index  = r_tidx;
    assign o_out.entry_last  = r_last;
    assign o_out.entry_empty = r_empty;
    assign o_out.blob_done   = r_done;
    assign o_out.blob_error  = r_err;

endmodule

// File: sv/efi_signature_list_parser_top.sv
// ============================================================================
// efi_signature_list_parser_top
// Signature-list parser: walks a blob byte by byte and emits entry data.
// ============================================================================
// Usage:
//   Write the wanted type GUIDs and match_enable, then blob_length; writing
//   blob_length starts a new blob. Blob bytes then enter on i_in, one per
//   transfer. Results leave on o_out: entry data bytes, empty-entry markers,
//   and a single blob_done or blob_error.
// Timing:
//   Body bytes are taken at one per cycle while the output register can
//   take a result; each result is registered in the cycle after its transfer
//   in. After the last byte of each 28-byte sublist header the input pauses
//   while the size checks run, and longer if a result is still waiting in the
//   output register; the modulo check is a restoring remainder unit that takes
//   one bit per cycle over 32 bits.
// Reset and stalls:
//   Reset clears configuration to zero and waits for a header. A result
//   that is not taken holds the output register; the input keeps moving
//   only while that register is empty or being drained in the same cycle.
//   Bytes after the end of the blob, after done or after an error are
//   accepted and dropped.
// ============================================================================
module efi_signature_list_parser_top
    import esl_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    esl_in_if.sink                 i_in,
    esl_out_if.source              o_out,
    input  logic                   i_cfg_we,
    input  logic [CfgIdxBits-1:0]  i_cfg_index,
    input  logic [CfgDataBits-1:0] i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    // Sequencing.
    esl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Fields, counters, checks and results.
    esl_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_byte_value (i_in.byte_value),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_out        (o_out)
    );

endmodule

// File: test/tb_efi_signature_list_parser_top.sv
// ============================================================================
// tb_efi_signature_list_parser_top
// Self-checking bench: builds signature-list blobs, predicts the parser's
// results byte by byte and compares every output transfer in order.
// ============================================================================
`timescale 1ns / 100ps

module tb_efi_signature_list_parser_top;
    import esl_pkg::*;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_data;
        logic       type_index;
        logic       entry_last;
        logic       entry_empty;
        logic       blob_done;
        logic       blob_error;
    } t_res;

    typedef enum logic [2:0] {
        PH_HDR, PH_SKIP, PH_LHDR, PH_OWNER, PH_DATA, PH_ERR, PH_DONE
    } t_phase;

    localparam int CycleLimit = 2000000;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CfgIdxBits-1:0] i_cfg_index;
    logic [CfgDataBits-1:0] i_cfg_data;

    esl_in_if  in_ch();
    esl_out_if out_ch();

    efi_signature_list_parser_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // Predictor state and configuration copy.
    logic [23:0] p_len;
    logic [63:0] p_ga_lo, p_ga_hi, p_gb_lo, p_gb_hi;
    logic [1:0]  p_en;
    t_phase      p_phase;
    logic [23:0] p_off;
    logic [63:0] p_guid0, p_guid1;
    logic [31:0] p_ls, p_hs, p_es, p_region, p_entry;
    logic        p_match;

    t_res expected_results[$];
    int   mismatches;
    int   results_seen;
    int   blobs_run;
    longint cycles;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Global watchdog.
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("timeout after %0d cycles", cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic void predictor_restart();
        p_phase = PH_HDR; p_off = 0; p_guid0 = 0; p_guid1 = 0;
        p_ls = 0; p_hs = 0; p_es = 0; p_region = 0; p_entry = 0; p_match = 0;
    endfunction

    function automatic void predictor_config(t_cfg_idx idx, logic [63:0] val);
        case (idx)
            CFG_BLOB_LENGTH: begin
                p_len = val[23:0];
                predictor_restart();
            end
            CFG_TYPE_A_LOW:   p_ga_lo = val;
            CFG_TYPE_A_HIGH:  p_ga_hi = val;
            CFG_TYPE_B_LOW:   p_gb_lo = val;
            CFG_TYPE_B_HIGH:  p_gb_hi = val;
            CFG_MATCH_ENABLE: p_en = val[1:0];
            default: ;
        endcase
    endfunction

    function automatic void next_entry();
        if (p_region == 0) begin
            p_phase = PH_HDR; p_entry = 0;
        end else begin
            p_phase = PH_OWNER; p_entry = 16;
        end
    endfunction

    // Works out the result (if any) that one blob byte causes.
    function automatic bit parse_byte(logic [7:0] b, output t_res r);
        longint rem, ls, hs, es, el;
        int i;
        bit data, last, empty, done, err;
        data = 0; last = 0; empty = 0; done = 0; err = 0; r = '0;
        if (p_phase == PH_ERR || p_phase == PH_DONE || p_off >= p_len) return 0;
        rem = longint'(p_len - p_off);
        case (p_phase)
            PH_HDR: begin
                i = p_entry;
                if (i == 0 && rem < 28) begin
                    err = 1;
                end else begin
                    if (i == 0) begin
                        p_guid0 = 0; p_guid1 = 0; p_ls = 0; p_hs = 0; p_es = 0;
                    end
                    if (i < 8) p_guid0[8*i +: 8] = b;
                    else if (i < 16) p_guid1[8*(i-8) +: 8] = b;
                    else if (i < 20) p_ls[8*(i-16) +: 8] = b;
                    else if (i < 24) p_hs[8*(i-20) +: 8] = b;
                    else p_es[8*(i-24) +: 8] = b;
                    i++;
                    if (i < 28) begin
                        p_entry = i;
                    end else begin
                        p_entry = 0;
                        ls = longint'(p_ls); hs = longint'(p_hs); es = longint'(p_es);
                        if (ls > rem + 27 || ls < 28 || ls - 28 < hs || es < 16) begin
                            err = 1;
                        end else begin
                            el = ls - 28 - hs;
                            if (el < es || el % es != 0) err = 1;
                            else if (p_en[0] && p_guid0 == p_ga_lo && p_guid1 == p_ga_hi)
                                p_match = 0;
                            else if (p_en[1] && p_guid0 == p_gb_lo && p_guid1 == p_gb_hi)
                                p_match = 1;
                            else begin
                                p_region = 32'(ls - 28);
                                p_phase = PH_SKIP;
                            end
                            if (!err && p_phase != PH_SKIP) begin
                                p_region = 32'(el);
                                if (hs > 0) begin
                                    p_entry = 32'(hs); p_phase = PH_LHDR;
                                end else begin
                                    p_entry = 16; p_phase = PH_OWNER;
                                end
                            end
                        end
                    end
                end
            end
            PH_SKIP: begin
                p_region--;
                if (p_region == 0) begin
                    p_phase = PH_HDR; p_entry = 0;
                end
            end
            PH_LHDR: begin
                p_entry--;
                if (p_entry == 0) begin
                    p_phase = PH_OWNER; p_entry = 16;
                end
            end
            PH_OWNER: begin
                p_region--; p_entry--;
                if (p_entry == 0) begin
                    if (p_es == 16) begin
                        last = 1; empty = 1; next_entry();
                    end else begin
                        p_phase = PH_DATA; p_entry = p_es - 16;
                    end
                end
            end
            default: begin
                p_region--; p_entry--; data = 1;
                if (p_entry == 0) begin
                    last = 1; next_entry();
                end
            end
        endcase
        if (err) p_phase = PH_ERR;
        else begin
            p_off++;
            if (p_off == p_len && p_phase == PH_HDR && p_entry == 0) begin
                done = 1; p_phase = PH_DONE;
            end
        end
        if (!(data || last || done || err)) return 0;
        r.data_byte   = data ? b : 8'h00;
        r.is_data     = data;
        r.type_index  = (data || last) ? p_match : 1'b0;
        r.entry_last  = last;
        r.entry_empty = empty;
        r.blob_done   = done;
        r.blob_error  = err;
        return 1;
    endfunction

    // Random gap: mostly zero or short, occasionally long.
    function automatic int gap_len();
        int k;
        k = $urandom_range(99);
        if (k < 55) return 0;
        if (k < 93) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // Receiver side: random stalls on ready, compare each output transfer.
    int rx_hold;
    initial rx_hold = 0;
    always @(posedge i_clk) begin
        t_res got, want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got = {out_ch.data_byte, out_ch.is_data, out_ch.type_index,
                       out_ch.entry_last, out_ch.entry_empty, out_ch.blob_done,
                       out_ch.blob_error};
                results_seen++;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %h", got);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %h actual %h", want, got);
                    end
                end
            end
            if (rx_hold > 0) begin
                rx_hold <= rx_hold - 1;
                out_ch.ready <= 1'b0;
            end else if (!out_ch.ready || !out_ch.valid) begin
                out_ch.ready <= 1'b1;
            end else begin
                rx_hold <= gap_len();
                out_ch.ready <= (gap_len() == 0);
            end
        end
    end

    task automatic cfg_write(t_cfg_idx idx, logic [63:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        predictor_config(idx, val);
    endtask

    // Sends one byte with a random gap ahead of it; predicts on acceptance.
    task automatic send_byte(logic [7:0] b);
        t_res r;
        int g;
        g = gap_len();
        if (g > 0) begin
            in_ch.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.byte_value <= b;
        do @(posedge i_clk); while (!in_ch.ready);
        if (parse_byte(b, r)) expected_results.push_back(r);
    endtask

    // Idle the input and wait for every expected result, plus a tail.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    byte blob[$];

    task automatic add_word(logic [31:0] w);
        for (int k = 0; k < 4; k++) blob.push_back(w[8*k +: 8]);
    endtask

    // Appends one sublist; sizes given explicitly so bad cases can be made.
    task automatic add_sublist(logic [63:0] lo, logic [63:0] hi, int hs, int es,
                               int n_entries);
        for (int k = 0; k < 8; k++) blob.push_back(lo[8*k +: 8]);
        for (int k = 0; k < 8; k++) blob.push_back(hi[8*k +: 8]);
        add_word(28 + hs + es * n_entries);
        add_word(hs);
        add_word(es);
        repeat (hs + es * n_entries) blob.push_back(8'($urandom_range(255)));
    endtask

    task automatic run_blob(int extra);
        cfg_write(CFG_BLOB_LENGTH, 64'(blob.size()));
        foreach (blob[k]) send_byte(blob[k]);
        repeat (extra) send_byte(8'($urandom_range(255)));
        drain();
        blob.delete();
        blobs_run++;
    endtask

    // Directed table: raw single bytes against a short, empty or very long blob
    // length, with the expected error typed in where it is obvious.
    typedef struct {
        logic [23:0] len;
        logic [7:0]  b;
        bit          has_exp;
        t_res        exp_res;
    } t_row;
    t_row rows[4];

    logic [63:0] ga_lo, ga_hi, gb_lo, gb_hi, glo, ghi;

    initial begin
        t_res r;
        int sel, es, hs, n;
        in_ch.valid = 1'b0;
        in_ch.byte_value = 8'h00;
        out_ch.ready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        mismatches = 0;
        results_seen = 0;
        blobs_run = 0;
        p_len = 0; p_ga_lo = 0; p_ga_hi = 0; p_gb_lo = 0; p_gb_hi = 0; p_en = 0;
        predictor_restart();
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Short header: error on the first byte; empty or long blob: nothing.
        rows[0] = '{24'd1,  8'hff, 1, t_res'(14'h0001)};
        rows[1] = '{24'd27, 8'h00, 1, t_res'(14'h0001)};
        rows[2] = '{24'd0,  8'h5a, 0, '0};
        rows[3] = '{24'hffffff, 8'h00, 0, '0};
        foreach (rows[k]) begin
            cfg_write(CFG_BLOB_LENGTH, 64'(rows[k].len));
            send_byte(rows[k].b);
            if (rows[k].has_exp) begin
                r = expected_results[$];
                if (r !== rows[k].exp_res) begin
                    mismatches++;
                    $display("table row %0d: expected %h predicted %h", k,
                             rows[k].exp_res, r);
                end
            end
            drain();
        end

        ga_lo = 64'hffffffffffffffff; ga_hi = 64'h0;
        gb_lo = 64'h0123456789abcdef; gb_hi = 64'hfedcba9876543210;
        cfg_write(CFG_TYPE_A_LOW, ga_lo);
        cfg_write(CFG_TYPE_A_HIGH, ga_hi);
        cfg_write(CFG_TYPE_B_LOW, gb_lo);
        cfg_write(CFG_TYPE_B_HIGH, gb_hi);
        cfg_write(CFG_MATCH_ENABLE, 64'd3);

        // Matched lists: empty entries, data entries, list header, skip.
        add_sublist(ga_lo, ga_hi, 0, 16, 2);
        add_sublist(gb_lo, gb_hi, 3, 18, 2);
        add_sublist(64'h1, 64'h2, 2, 16, 1);
        run_blob(2);
        // Bad size combinations.
        add_sublist(ga_lo, ga_hi, 0, 15, 2); run_blob(0);
        add_sublist(ga_lo, ga_hi, 0, 20, 0); run_blob(0);
        add_sublist(ga_lo, ga_hi, 1, 17, 1); blob[20] = 8'h02; run_blob(0);
        add_sublist(ga_lo, ga_hi, 0, 16, 1); blob[16] = 8'hff; blob[19] = 8'hff;
        run_blob(0);
        add_sublist(ga_lo, ga_hi, 0, 16, 1); blob[16] = 8'd20; run_blob(0);
        // Header size over list size minus 28.
        add_sublist(ga_lo, ga_hi, 0, 16, 1); blob[20] = 8'hff; blob[23] = 8'h80;
        run_blob(0);
        // Overrun: list size claims more than the blob holds.
        add_sublist(gb_lo, gb_hi, 0, 16, 2); blob.delete(blob.size() - 1);
        run_blob(1);

        // Random phase: mostly well-formed blobs, some corrupted.
        while (blobs_run < 10) begin
            case ($urandom_range(3))
                0: cfg_write(CFG_MATCH_ENABLE, 64'($urandom_range(3)));
                1: begin
                    ga_lo = {$urandom, $urandom}; ga_hi = {$urandom, $urandom};
                    cfg_write(CFG_TYPE_A_LOW, ga_lo); cfg_write(CFG_TYPE_A_HIGH, ga_hi);
                end
                2: begin
                    gb_lo = {$urandom, $urandom}; gb_hi = {$urandom, $urandom};
                    cfg_write(CFG_TYPE_B_LOW, gb_lo); cfg_write(CFG_TYPE_B_HIGH, gb_hi);
                end
                default: ;
            endcase
            repeat ($urandom_range(2, 1)) begin
                sel = $urandom_range(2);
                glo = sel == 0 ? ga_lo : sel == 1 ? gb_lo : {$urandom, $urandom};
                ghi = sel == 0 ? ga_hi : sel == 1 ? gb_hi : {$urandom, $urandom};
                es = $urandom_range(3) == 0 ? 16 : $urandom_range(20, 16);
                hs = $urandom_range(3) == 0 ? $urandom_range(3) : 0;
                n = $urandom_range(2, 1);
                add_sublist(glo, ghi, hs, es, n);
            end
            if ($urandom_range(5) == 0)
                blob[$urandom_range(blob.size() - 1)] = 8'($urandom_range(255));
            if ($urandom_range(9) == 0) blob.delete(blob.size() - 1);
            run_blob($urandom_range(9) == 0 ? 3 : 0);
        end
        cfg_write(CFG_MATCH_ENABLE, 64'd0);
        cfg_write(CFG_BLOB_LENGTH, 64'd0);
        drain();

        $display("Parsed %0d blobs with %0d result transfers checked,", blobs_run,
                 results_seen);
        $display("covering matched, skipped, empty-entry and malformed lists.");
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

// File: efi_signature_list_parser_top.f
sv/esl_pkg.sv
sv/esl_in_if.sv
sv/esl_out_if.sv
sv/esl_ctrl.sv
sv/esl_dp.sv
sv/efi_signature_list_parser_top.sv
test/tb_efi_signature_list_parser_top.sv
